// File: rtl/core/pressure_channel_zero_and_settle_macros.svh
// Assertion macros for the pressure channel zero-and-settle block.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef PRESSURE_CHANNEL_ZERO_AND_SETTLE_MACROS_SVH
`define PRESSURE_CHANNEL_ZERO_AND_SETTLE_MACROS_SVH

// Check a consequence in the same cycle as its condition.
`define PCZ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pressure channel assertion failed");

// Check a consequence in the cycle after its condition.
`define PCZ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pressure channel assertion failed");

`endif

// File: rtl/core/pcz_pkg.sv
// Shared types, codes and scaling constants for the pressure channel block.
// No dependencies; imported by pcz_track, pcz_scale and the top level.
`timescale 1ns / 1ps

package pcz_pkg;

    localparam int CHANNEL_COUNT_DEF = 4;
    localparam int DISPLAY_COUNT     = 4;

    localparam int COEF_A_W = 17;
    localparam int COEF_D_W = 19;
    localparam int COEF_B_W = 18;
    localparam int NUM_W    = 48;
    localparam int REM_W    = 21;

    // Display units; every code is used.
    typedef enum logic [1:0] {
        UNIT_MBAR = 2'd0,
        UNIT_KPA  = 2'd1,
        UNIT_PSI  = 2'd2,
        UNIT_MMHG = 2'd3
    } t_unit;

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_CAL    = 2'd1,
        MODE_CLEAR  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        REG_UNIT   = 2'd0,
        REG_SETTLE = 2'd1,
        REG_MARKER = 2'd2
    } t_reg;

    // Rounded quotient q = floor((A * mag + B) / D), with B exactly D / 2.
    localparam int KPA_A  = 1;
    localparam int KPA_B  = 5;
    localparam int KPA_D  = 10;
    localparam int PSI_A  = 5000;
    localparam int PSI_B  = 172369;
    localparam int PSI_D  = 344738;
    localparam int MMHG_A = 100000;
    localparam int MMHG_B = 66661;
    localparam int MMHG_D = 133322;

    // Reciprocals floor(2^32 * A / D), used for the quotient estimate.
    localparam logic [31:0] KPA_M  = 32'((64'd1 << 32) * 64'(KPA_A) / 64'(KPA_D));
    localparam logic [31:0] PSI_M  = 32'((64'd1 << 32) * 64'(PSI_A) / 64'(PSI_D));
    localparam logic [31:0] MMHG_M = 32'((64'd1 << 32) * 64'(MMHG_A) / 64'(MMHG_D));

    typedef struct packed {
        logic [31:0]         m;
        logic [COEF_A_W-1:0] a;
        logic [COEF_B_W-1:0] b;
        logic [COEF_D_W-1:0] d;
    } t_coef;

    typedef struct packed {
        logic [1:0]  unit;
        logic [15:0] settle;
        logic [31:0] marker;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  mode;
        logic [1:0]  channel;
        logic [31:0] raw;
        logic [31:0] now;
    } t_item;

    typedef struct packed {
        logic                               valid;
        logic [1:0]                         channel;
        logic [DISPLAY_COUNT-1:0]           lost;
        logic [DISPLAY_COUNT-1:0][31:0]     cal;
    } t_snap;

    function automatic t_coef unit_coef(input logic [1:0] unit);
        t_coef c;
        c = '0;
        case (unit)
            UNIT_KPA: begin
                c.m = KPA_M;
                c.a = COEF_A_W'(KPA_A);
                c.b = COEF_B_W'(KPA_B);
                c.d = COEF_D_W'(KPA_D);
            end
            UNIT_PSI: begin
                c.m = PSI_M;
                c.a = COEF_A_W'(PSI_A);
                c.b = COEF_B_W'(PSI_B);
                c.d = COEF_D_W'(PSI_D);
            end
            UNIT_MMHG: begin
                c.m = MMHG_M;
                c.a = COEF_A_W'(MMHG_A);
                c.b = COEF_B_W'(MMHG_B);
                c.d = COEF_D_W'(MMHG_D);
            end
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/core/pcz_track.sv
// Per-channel connect, settle and zero-offset state, plus the result snapshot.
// Depends on pcz_pkg.
`timescale 1ns / 1ps

module pcz_track #(
    parameter int CHANNEL_COUNT = pcz_pkg::CHANNEL_COUNT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  pcz_pkg::t_item i_item,
    input  pcz_pkg::t_cfg  i_cfg,
    output pcz_pkg::t_snap o_snap
);
    import pcz_pkg::*;

    logic        r_seen    [CHANNEL_COUNT];
    logic        r_settled [CHANNEL_COUNT];
    logic        r_lost    [CHANNEL_COUNT];
    logic [31:0] r_stamp   [CHANNEL_COUNT];
    logic [31:0] r_last    [CHANNEL_COUNT];
    logic [31:0] r_offset  [CHANNEL_COUNT];
    logic [31:0] r_cal     [CHANNEL_COUNT];

    logic        n_seen    [CHANNEL_COUNT];
    logic        n_settled [CHANNEL_COUNT];
    logic        n_lost    [CHANNEL_COUNT];
    logic [31:0] n_stamp   [CHANNEL_COUNT];
    logic [31:0] n_last    [CHANNEL_COUNT];
    logic [31:0] n_offset  [CHANNEL_COUNT];
    logic [31:0] n_cal     [CHANNEL_COUNT];

    logic  emit;
    t_snap r_snap;
    t_snap n_snap;

    always_comb begin
        logic [32:0] diff;
        logic [31:0] elapsed;
        n_seen    = r_seen;
        n_settled = r_settled;
        n_lost    = r_lost;
        n_stamp   = r_stamp;
        n_last    = r_last;
        n_offset  = r_offset;
        n_cal     = r_cal;
        emit      = 1'b0;
        diff      = '0;
        elapsed   = '0;
        if (i_valid) begin
            case (i_item.mode)
                MODE_CLEAR: begin
                    for (int c = 0; c < CHANNEL_COUNT; c++) n_offset[c] = '0;
                end
                MODE_CAL: begin
                    for (int c = 0; c < CHANNEL_COUNT; c++) begin
                        if (int'(i_item.channel) == c && r_last[c] != i_cfg.marker) begin
                            n_offset[c] = r_last[c];
                        end
                    end
                end
                MODE_SAMPLE: begin
                    for (int c = 0; c < CHANNEL_COUNT; c++) begin
                        if (int'(i_item.channel) == c) begin
                            elapsed = i_item.now - r_stamp[c];
                            diff    = {i_item.raw[31], i_item.raw} - {r_offset[c][31], r_offset[c]};
                            if (i_item.raw == i_cfg.marker) begin
                                n_lost[c]    = 1'b1;
                                n_settled[c] = 1'b0;
                                n_seen[c]    = 1'b0;
                                emit         = 1'b1;
                            end else if (!r_seen[c]) begin
                                // first good sample opens the settle window
                                n_seen[c]    = 1'b1;
                                n_stamp[c]   = i_item.now;
                                n_settled[c] = 1'b0;
                            end else if (!r_settled[c] && elapsed < 32'(i_cfg.settle)) begin
                                n_settled[c] = 1'b0;
                            end else begin
                                n_settled[c] = 1'b1;
                                n_last[c]    = i_item.raw;
                                n_lost[c]    = 1'b0;
                                emit         = 1'b1;
                                if (diff[32] != diff[31]) begin
                                    n_cal[c] = diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                                end else begin
                                    n_cal[c] = diff[31:0];
                                end
                            end
                        end
                    end
                end
                default: emit = 1'b0;
            endcase
        end
    end

    assign n_snap.valid   = i_valid & emit;
    assign n_snap.channel = i_item.channel;

    for (genvar l = 0; l < DISPLAY_COUNT; l++) begin : g_lane
        if (l < CHANNEL_COUNT) begin : g_live
            assign n_snap.cal[l]  = n_cal[l];
            assign n_snap.lost[l] = n_lost[l];
        end else begin : g_none
            assign n_snap.cal[l]  = '0;
            assign n_snap.lost[l] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
                r_seen[c]    <= 1'b0;
                r_settled[c] <= 1'b0;
                r_lost[c]    <= 1'b0;
                r_stamp[c]   <= '0;
                r_last[c]    <= '0;
                r_offset[c]  <= '0;
                r_cal[c]     <= '0;
            end
            r_snap.valid <= 1'b0;
        end else if (i_en) begin
            r_seen    <= n_seen;
            r_settled <= n_settled;
            r_lost    <= n_lost;
            r_stamp   <= n_stamp;
            r_last    <= n_last;
            r_offset  <= n_offset;
            r_cal     <= n_cal;
            r_snap    <= n_snap;
        end
    end

    assign o_snap = r_snap;

endmodule

// File: rtl/core/pcz_scale.sv
// One display lane: converts a calibrated 0.01 mbar value to the selected unit.
// Three registered stages (multiply, remainder, correct); depends on pcz_pkg.
`timescale 1ns / 1ps

module pcz_scale (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [31:0]   i_value,
    input  logic          i_lost,
    input  pcz_pkg::t_cfg i_cfg,
    output logic [31:0]   o_display
);
    import pcz_pkg::*;

    t_coef coef;
    logic  is_marker;
    logic  neg;
    logic [31:0] mag;

    logic                r1_pass;
    logic [31:0]         r1_pass_val;
    logic                r1_neg;
    logic [63:0]         r1_prod;
    logic [NUM_W-1:0]    r1_num;
    logic [COEF_D_W-1:0] r1_d;

    logic                r2_pass;
    logic [31:0]         r2_pass_val;
    logic                r2_neg;
    logic [31:0]         r2_q0;
    logic [REM_W-1:0]    r2_rem;
    logic [COEF_D_W-1:0] r2_d;

    logic [31:0] r_out;

    logic [64:0] rounded;
    logic [31:0] q0;
    logic [49:0] back;
    logic [31:0] q;

    assign coef      = unit_coef(i_cfg.unit);
    assign is_marker = i_lost || (i_value == i_cfg.marker);
    assign neg       = i_value[31];
    assign mag       = neg ? (32'd0 - i_value) : i_value;

    // estimate is the rounded quotient or one below it
    assign rounded = 65'(r1_prod) + (65'd1 << 31);
    assign q0      = rounded[63:32];
    assign back    = 50'(r1_num) - 50'(q0) * 50'(r1_d);
    assign q       = r2_q0 + 32'(r2_rem >= REM_W'(r2_d));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pass     <= is_marker || (i_cfg.unit == UNIT_MBAR);
            r1_pass_val <= is_marker ? i_cfg.marker : i_value;
            r1_neg      <= neg;
            r1_prod     <= 64'(mag) * 64'(coef.m);
            r1_num      <= NUM_W'(mag) * NUM_W'(coef.a) + NUM_W'(coef.b);
            r1_d        <= coef.d;

            r2_pass     <= r1_pass;
            r2_pass_val <= r1_pass_val;
            r2_neg      <= r1_neg;
            r2_q0       <= q0;
            r2_rem      <= back[REM_W-1:0];
            r2_d        <= r1_d;

            r_out       <= r2_pass ? r2_pass_val : (r2_neg ? (32'd0 - q) : q);
        end
    end

    assign o_display = r_out;

endmodule

// File: rtl/core/pressure_channel_zero_and_settle.sv
// Pressure channel zero-and-settle top level: input register, channel tracker,
// four display lanes and output register. Depends on pcz_pkg, pcz_track,
// pcz_scale and the assertion macro header.
`timescale 1ns / 1ps
`include "pressure_channel_zero_and_settle_macros.svh"

// Accepts one request per clock unless a finished result waits, and returns
// at most one result per request. A sample request walks through five
// registers: input register, channel state update with result snapshot, then
// the three stages of the unit conversion lanes, the last of which is the
// output register. The whole pipeline advances together whenever the output
// register is empty or being taken, so throughput is one request per cycle
// and s_axis_tready drops only while a finished result waits. The rate is set
// by the per-channel state update, which reads the input register into the
// result snapshot. Calibrate, clear, spare-mode requests and dropped samples
// produce no result. Configuration writes are always taken and should only
// be made with the pipeline drained.
module pressure_channel_zero_and_settle #(
    parameter int CHANNEL_COUNT = pcz_pkg::CHANNEL_COUNT_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // request stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // raw_pressure[31:0], now_ms[63:32]
    input  logic [3:0]   s_axis_tuser,   // mode[1:0], channel[3:2]
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata,   // display_one..display_four[127:0],
                                         // lost_mask[131:128], zero pad
    output logic [1:0]   m_axis_tuser,   // source_channel[1:0]
    // configuration writes
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    import pcz_pkg::*;

    localparam logic [DISPLAY_COUNT-1:0] LANE_MASK = (CHANNEL_COUNT >= DISPLAY_COUNT) ?
        {DISPLAY_COUNT{1'b1}} : DISPLAY_COUNT'((1 << CHANNEL_COUNT) - 1);

    logic pipe_en;

    // configuration registers
    t_cfg r_cfg;

    // input register
    logic  r_in_v;
    t_item r_in;

    t_snap snap;

    // sideband carried alongside the lanes
    logic                     r_s1_v, r_s2_v, r_out_v;
    logic [1:0]               r_s1_ch, r_s2_ch, r_out_ch;
    logic [DISPLAY_COUNT-1:0] r_s1_mask, r_s2_mask, r_out_mask;

    logic [DISPLAY_COUNT-1:0][31:0] display;

    // advance everything when the output slot is free or being taken
    assign pipe_en       = !r_out_v || m_axis_tready;
    assign s_axis_tready = pipe_en;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.unit   <= UNIT_MBAR;
            r_cfg.settle <= 16'd1000;
            r_cfg.marker <= 32'd999900;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_UNIT:   r_cfg.unit   <= i_cfg_data[1:0];
                REG_SETTLE: r_cfg.settle <= i_cfg_data[15:0];
                REG_MARKER: r_cfg.marker <= i_cfg_data;
                default:    r_cfg        <= r_cfg;   // drop writes past the list
            endcase
        end
    end

    // hold the request; payload needs no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (pipe_en) begin
            r_in_v <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_in.mode    <= s_axis_tuser[1:0];
            r_in.channel <= s_axis_tuser[3:2];
            r_in.raw     <= s_axis_tdata[31:0];
            r_in.now     <= s_axis_tdata[63:32];
        end
    end

    pcz_track #(
        .CHANNEL_COUNT(CHANNEL_COUNT)
    ) u_track (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (pipe_en),
        .i_valid(r_in_v),
        .i_item (r_in),
        .i_cfg  (r_cfg),
        .o_snap (snap)
    );

    for (genvar l = 0; l < DISPLAY_COUNT; l++) begin : g_scale
        pcz_scale u_scale (
            .i_clk    (i_clk),
            .i_en     (pipe_en),
            .i_value  (snap.cal[l]),
            .i_lost   (snap.lost[l]),
            .i_cfg    (r_cfg),
            .o_display(display[l])
        );
    end

    // advance valid bits with the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (pipe_en) begin
            r_s1_v  <= snap.valid;
            r_s2_v  <= r_s1_v;
            r_out_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s1_ch    <= snap.channel;
            r_s1_mask  <= snap.lost;
            r_s2_ch    <= r_s1_ch;
            r_s2_mask  <= r_s1_mask;
            r_out_ch   <= r_s2_ch;
            r_out_mask <= r_s2_mask;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tuser  = r_out_ch;
    assign m_axis_tdata  = {4'd0, r_out_mask, display[3], display[2], display[1], display[0]};

    // non-sample requests never produce a snapshot
    `PCZ_ASSERT_NEXT(a_no_result_for_control, r_in_v && pipe_en && (r_in.mode != MODE_SAMPLE), !snap.valid)
    // a snapshot carries the channel of the request that made it
    `PCZ_ASSERT_NEXT(a_snap_channel, r_in_v && pipe_en, !snap.valid || (snap.channel == $past(r_in.channel)))
    // lanes past the channel count never report lost
    `PCZ_ASSERT_NOW(a_mask_in_range, m_axis_tvalid, (r_out_mask & ~LANE_MASK) == '0)

endmodule

// File: tb/sv/pressure_channel_zero_and_settle_checker.sv
// Result checker for the pressure channel zero-and-settle block: tracks every
// channel, predicts the display frame each request causes and compares it.
// Depends on pcz_pkg for the mode, unit and register codes.
`timescale 1ns / 1ps

module pressure_channel_zero_and_settle_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // raw_pressure[31:0], now_ms[63:32]
    input  logic [3:0]   s_axis_tuser,   // mode[1:0], channel[3:2]
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [135:0] m_axis_tdata,   // display_one..display_four[127:0],
                                         // lost_mask[131:128], zero pad
    input  logic [1:0]   m_axis_tuser,   // source_channel[1:0]
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    output logic [31:0]  o_fail_count,
    output logic [31:0]  o_results_due
);
    import pcz_pkg::*;

    localparam int CHANNELS = 4;
    localparam logic signed [63:0] CAL_HI = 64'sd2147483647;
    localparam logic signed [63:0] CAL_LO = -64'sd2147483648;

    typedef struct packed {
        logic [1:0]       chan;
        logic [3:0][31:0] disp;
        logic [3:0]       mask;
    } t_display_frame;

    t_display_frame frames_due[$];
    t_display_frame want;
    t_display_frame got;

    // configuration copy
    logic [1:0]         unit_sel;
    logic [15:0]        settle_win;
    logic signed [31:0] marker;

    // per-channel state
    logic               ch_seen     [CHANNELS];
    logic               ch_settled  [CHANNELS];
    logic [31:0]        ch_stamp    [CHANNELS];
    logic signed [31:0] ch_last_raw [CHANNELS];
    logic signed [31:0] ch_offset   [CHANNELS];
    logic signed [31:0] ch_cal      [CHANNELS];
    logic               ch_lost     [CHANNELS];

    logic [1:0]         rq_mode;
    logic [1:0]         rq_chan;
    logic signed [31:0] rq_raw;
    logic [31:0]        rq_now;
    logic signed [63:0] rq_diff;

    int    fails = 0;
    string disp_name [4] = '{"display_one", "display_two", "display_three", "display_four"};

    initial begin
        o_fail_count  = '0;
        o_results_due = '0;
    end

    // Build the frame for all channels in the current unit and queue it.
    task automatic push_frame(input logic [1:0] src);
        t_display_frame     f;
        logic signed [63:0] wide;
        logic [63:0]        mag;
        logic [63:0]        num;
        logic [63:0]        den;
        logic [63:0]        q;
        f.chan = src;
        f.mask = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (ch_lost[c]) begin
                f.disp[c] = marker;
                f.mask[c] = 1'b1;
            end else if (ch_cal[c] == marker || unit_sel == UNIT_MBAR) begin
                f.disp[c] = ch_cal[c];
            end else begin
                case (unit_sel)
                    UNIT_KPA: begin num = 64'd1;      den = 64'd10;     end
                    UNIT_PSI: begin num = 64'd10000;  den = 64'd689476; end
                    default:  begin num = 64'd100000; den = 64'd133322; end
                endcase
                // round half away from zero on the magnitude
                wide = ch_cal[c];
                mag  = ch_cal[c][31] ? 64'(-wide) : 64'(wide);
                q    = (mag * num * 64'd2 + den) / (den * 64'd2);
                f.disp[c] = ch_cal[c][31] ? 32'(64'd0 - q) : 32'(q);
            end
        end
        frames_due.push_back(f);
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, actual %h", name, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            unit_sel   = UNIT_MBAR;
            settle_win = 16'd1000;
            marker     = 32'sd999900;
            for (int c = 0; c < CHANNELS; c++) begin
                ch_seen[c]     = 1'b0;
                ch_settled[c]  = 1'b0;
                ch_stamp[c]    = '0;
                ch_last_raw[c] = '0;
                ch_offset[c]   = '0;
                ch_cal[c]      = '0;
                ch_lost[c]     = 1'b0;
            end
            frames_due.delete();
        end else begin
            // retire the oldest expectation against the taken result
            if (m_axis_tvalid && m_axis_tready) begin
                got.chan = m_axis_tuser;
                got.disp = m_axis_tdata[127:0];
                got.mask = m_axis_tdata[131:128];
                if (frames_due.size() == 0) begin
                    $error("result from channel %0d with no expectation waiting", got.chan);
                    fails++;
                end else begin
                    want = frames_due.pop_front();
                    compare_field("source_channel", 32'(want.chan), 32'(got.chan));
                    for (int c = 0; c < CHANNELS; c++)
                        compare_field(disp_name[c], want.disp[c], got.disp[c]);
                    compare_field("lost_mask", 32'(want.mask), 32'(got.mask));
                end
            end

            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_UNIT:   unit_sel   = i_cfg_data[1:0];
                    REG_SETTLE: settle_win = i_cfg_data[15:0];
                    REG_MARKER: marker     = i_cfg_data;
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready) begin
                rq_mode = s_axis_tuser[1:0];
                rq_chan = s_axis_tuser[3:2];
                rq_raw  = s_axis_tdata[31:0];
                rq_now  = s_axis_tdata[63:32];
                case (rq_mode)
                    MODE_CLEAR: begin
                        for (int c = 0; c < CHANNELS; c++)
                            ch_offset[c] = '0;
                    end
                    MODE_CAL: begin
                        if (ch_last_raw[rq_chan] != marker)
                            ch_offset[rq_chan] = ch_last_raw[rq_chan];
                    end
                    MODE_SAMPLE: begin
                        if (rq_raw == marker) begin
                            ch_lost[rq_chan]    = 1'b1;
                            ch_settled[rq_chan] = 1'b0;
                            ch_seen[rq_chan]    = 1'b0;
                            push_frame(rq_chan);
                        end else if (!ch_seen[rq_chan]) begin
                            // first good sample opens the settle window
                            ch_seen[rq_chan]    = 1'b1;
                            ch_stamp[rq_chan]   = rq_now;
                            ch_settled[rq_chan] = 1'b0;
                        end else if (ch_settled[rq_chan] ||
                                     (rq_now - ch_stamp[rq_chan]) >= 32'(settle_win)) begin
                            ch_settled[rq_chan] = 1'b1;
                            rq_diff = rq_raw;
                            rq_diff = rq_diff - ch_offset[rq_chan];
                            if (rq_diff > CAL_HI) rq_diff = CAL_HI;
                            if (rq_diff < CAL_LO) rq_diff = CAL_LO;
                            ch_last_raw[rq_chan] = rq_raw;
                            ch_cal[rq_chan]      = rq_diff[31:0];
                            ch_lost[rq_chan]     = 1'b0;
                            push_frame(rq_chan);
                        end
                    end
                    default: ;
                endcase
            end
        end
        o_fail_count  <= fails;
        o_results_due <= frames_due.size();
    end

endmodule

// File: tb/sv/pressure_channel_zero_and_settle_tb.sv
// Top of the pressure channel zero-and-settle testbench: clock, reset,
// request and register stimulus, receiver stalls, watchdog and verdict.
// Depends on pcz_pkg, the block and pressure_channel_zero_and_settle_checker.
`timescale 1ns / 1ps

module pressure_channel_zero_and_settle_tb;
    import pcz_pkg::*;

    // codes the package leaves unnamed but the fields allow
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam logic [1:0] REG_SPARE  = 2'd3;

    localparam logic signed [31:0] S32_MIN        = 32'sh8000_0000;
    localparam logic signed [31:0] S32_MAX        = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] DEFAULT_MARKER = 32'sd999900;

    // idle wait after the last expected result so requests in flight can leave
    localparam int PIPE_QUIET  = 8;
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 210;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata  = '0;    // raw_pressure[31:0], now_ms[63:32]
    logic [3:0]   s_axis_tuser  = '0;    // mode[1:0], channel[3:2]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;          // display_one..display_four[127:0],
                                         // lost_mask[131:128], zero pad
    logic [1:0]   m_axis_tuser;          // source_channel[1:0]
    logic         i_cfg_valid   = 1'b0;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index   = '0;
    logic [31:0]  i_cfg_data    = '0;

    logic [31:0]  fail_count;
    logic [31:0]  results_due;

    int ready_tick  = 0;
    int ready_style = 0;
    int quiet       = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    pressure_channel_zero_and_settle dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    pressure_channel_zero_and_settle_checker checker_u (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_results_due (results_due)
    );

    // Receiver: periodically switch style - always ready, mostly ready,
    // mostly stalled, or a fixed repeating stall pattern.
    always @(posedge i_clk) begin
        ready_tick <= ready_tick + 1;
        if (ready_tick % 150 == 0)
            ready_style <= $urandom_range(0, 3);
        case (ready_style)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 9) < 7);
            2:       m_axis_tready <= ($urandom_range(0, 9) < 2);
            default: m_axis_tready <= (ready_tick % 8) >= 2;
        endcase
    end

    // Watchdog: end the run once nothing has moved for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offer one request and hold it until the block takes it.
    task automatic send_request(input logic [1:0] mode, input logic [1:0] chan,
                                input logic signed [31:0] raw, input logic [31:0] stamp);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {stamp, raw};
        s_axis_tuser  <= {chan, mode};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Write one register, then drop valid before returning.
    task automatic write_reg(input logic [1:0] index, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop sending, wait for every expected result, then let dropped
    // requests still in flight leave the pipeline.
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (results_due != 0) @(posedge i_clk);
        repeat (PIPE_QUIET) @(posedge i_clk);
    endtask

    initial begin
        int                 phase;
        int                 n;
        int                 burst_left;
        int                 gap;
        int                 pick;
        logic [1:0]         md;
        logic [1:0]         ch;
        logic signed [31:0] raw;
        logic [31:0]        stamp;
        logic [31:0]        ms_now;
        logic [1:0]         unit_now;
        logic [15:0]        settle_now;
        logic signed [31:0] marker_now;

        burst_left = 0;
        ms_now     = 32'hFFF0_0000;
        settle_now = 16'd1000;
        marker_now = DEFAULT_MARKER;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed: reset settings (mbar, 1000 ms window, default marker)
        // settle window: first sample dropped, one inside dropped, edge passes
        send_request(MODE_SAMPLE, 2'd0, 32'sd500, 32'd100);
        send_request(MODE_SAMPLE, 2'd0, 32'sd600, 32'd1099);
        send_request(MODE_SAMPLE, 2'd0, 32'sd700, 32'd1100);
        // marker sample flags channel two lost and emits
        send_request(MODE_SAMPLE, 2'd1, DEFAULT_MARKER, 32'd1150);
        // calibrate a channel that was never sampled
        send_request(MODE_CAL, 2'd2, 32'sd0, 32'd1160);
        // offset at the negative extreme, then saturate positive
        send_request(MODE_SAMPLE, 2'd0, S32_MIN, 32'd1200);
        send_request(MODE_CAL, 2'd0, 32'sd0, 32'd1250);
        send_request(MODE_SAMPLE, 2'd0, S32_MAX, 32'd1300);
        // window measured across the timestamp wrap
        send_request(MODE_SAMPLE, 2'd3, S32_MAX, 32'hFFFF_FF00);
        send_request(MODE_SAMPLE, 2'd3, 32'sd5, 32'h0000_02F0);
        send_request(MODE_CAL, 2'd3, 32'sd0, 32'h0000_02F8);
        // calibrated value lands exactly on the marker
        send_request(MODE_SAMPLE, 2'd3, DEFAULT_MARKER + 32'sd5, 32'h0000_0300);
        send_request(MODE_SAMPLE, 2'd3, S32_MIN, 32'h0000_0310);
        send_request(MODE_CAL, 2'd3, 32'sd0, 32'h0000_0318);
        send_request(MODE_SAMPLE, 2'd3, S32_MAX, 32'h0000_0320);
        // clear offsets, unused mode, then reconnect the lost channel
        send_request(MODE_CLEAR, 2'd2, 32'sd0, 32'd4000);
        send_request(MODE_SPARE, 2'd1, 32'sd77, 32'd4100);
        send_request(MODE_SAMPLE, 2'd1, -32'sd12345, 32'd5000);
        send_request(MODE_SAMPLE, 2'd1, -32'sd12345, 32'd7000);
        drain_pipeline();

        // marker moved onto a stored raw value: calibrate is ignored and the
        // display shows the marker; zero window lets the second sample pass
        write_reg(REG_MARKER, -32'sd12345);
        write_reg(REG_UNIT, 32'(UNIT_PSI));
        write_reg(REG_SETTLE, 32'd0);
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        send_request(MODE_CAL, 2'd1, 32'sd0, 32'd7100);
        send_request(MODE_SAMPLE, 2'd2, 32'sd7, 32'd10);
        send_request(MODE_SAMPLE, 2'd2, 32'sd1000, 32'd10);
        drain_pipeline();

        // kPa ties round away from zero
        write_reg(REG_UNIT, 32'(UNIT_KPA));
        send_request(MODE_SAMPLE, 2'd0, 32'sd15, 32'd20);
        send_request(MODE_SAMPLE, 2'd0, -32'sd15, 32'd21);
        drain_pipeline();
        write_reg(REG_UNIT, 32'(UNIT_MMHG));
        send_request(MODE_SAMPLE, 2'd0, S32_MIN, 32'd22);
        settle_now = 16'd0;
        marker_now = -32'sd12345;

        // ---- random phases, each under its own settings
        for (phase = 0; phase < PHASES; phase++) begin
            drain_pipeline();
            case (phase)
                0: begin
                    unit_now   = UNIT_MMHG;
                    settle_now = 16'hFFFF;
                    marker_now = S32_MIN;
                end
                1: begin
                    unit_now   = UNIT_MBAR;
                    settle_now = 16'd0;
                    marker_now = S32_MAX;
                end
                default: begin
                    unit_now = 2'($urandom_range(0, 3));
                    case ($urandom_range(0, 5))
                        0:       settle_now = 16'd0;
                        1:       settle_now = 16'($urandom_range(1, 8));
                        2:       settle_now = 16'($urandom_range(10, 200));
                        3:       settle_now = 16'd1000;
                        4:       settle_now = 16'hFFFF;
                        default: settle_now = 16'($urandom_range(0, 65535));
                    endcase
                    case ($urandom_range(0, 4))
                        0:       marker_now = DEFAULT_MARKER;
                        1:       marker_now = S32_MIN;
                        2:       marker_now = S32_MAX;
                        3:       marker_now = $signed($urandom_range(0, 400000)) - 200000;
                        default: marker_now = $urandom;
                    endcase
                end
            endcase
            write_reg(REG_UNIT, 32'(unit_now));
            write_reg(REG_SETTLE, 32'(settle_now));
            write_reg(REG_MARKER, marker_now);
            if ($urandom_range(0, 1) == 1)
                ms_now = $urandom;

            for (n = 0; n < PHASE_ITEMS; n++) begin
                // hold off once until every result is home
                if (phase == 3 && n == PHASE_ITEMS / 2)
                    drain_pipeline();

                // bursts with random gaps; some bursts run back to back
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
                    if (gap > 0) begin
                        s_axis_tvalid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
                burst_left--;

                pick = $urandom_range(0, 99);
                if (pick < 84)      md = MODE_SAMPLE;
                else if (pick < 93) md = MODE_CAL;
                else if (pick < 97) md = MODE_CLEAR;
                else                md = MODE_SPARE;
                ch = 2'($urandom_range(0, 3));

                pick = $urandom_range(0, 99);
                if (pick < 6) begin
                    raw = marker_now;
                end else if (pick < 60) begin
                    raw = $signed($urandom_range(0, 400000)) - 200000;
                end else if (pick < 75) begin
                    case ($urandom_range(0, 5))
                        0:       raw = S32_MIN;
                        1:       raw = S32_MIN + 32'sd1;
                        2:       raw = S32_MAX;
                        3:       raw = -32'sd1;
                        4:       raw = 32'sd0;
                        default: raw = 32'sd1;
                    endcase
                end else begin
                    raw = $urandom;
                end

                // advance the stamp by a random step of up to a third of the window plus two;
                // now and then jump or send an out-of-order stamp
                ms_now = ms_now + $urandom_range(0, int'(settle_now) / 3 + 2);
                if ($urandom_range(0, 99) == 0)
                    ms_now = $urandom;
                stamp = ($urandom_range(0, 99) < 3) ? $urandom : ms_now;

                send_request(md, ch, raw, stamp);
            end
        end

        drain_pipeline();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/pcz_pkg.sv
rtl/core/pcz_track.sv
rtl/core/pcz_scale.sv
rtl/core/pressure_channel_zero_and_settle.sv
tb/sv/pressure_channel_zero_and_settle_checker.sv
tb/sv/pressure_channel_zero_and_settle_tb.sv
